>>> rtl/swt_pkg.sv
// Package for the sleep and wait table: widths, modes, sequencer states.
// No dependencies; used by sleep_and_wait_table.sv, the top level of the block.
package swt_pkg;

  localparam int TIMED_ENTRIES = 16;
  localparam int WAIT_ENTRIES  = 16;
  localparam int TIDX_W = (TIMED_ENTRIES > 1) ? $clog2(TIMED_ENTRIES) : 1;
  localparam int WIDX_W = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
  localparam int TCNT_W = $clog2(TIMED_ENTRIES + 1);
  localparam int WCNT_W = $clog2(WAIT_ENTRIES + 1);
  localparam logic [29:0] TICK_NANOS_RESET = 30'd1000000;
  localparam logic [29:0] NANOS_PER_SEC = 30'd1000000000;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_SLEEP  = 3'd1,
    MODE_WAIT   = 3'd2,
    MODE_WAKEUP = 3'd3,
    MODE_CHECK  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_EMIT,
    ST_DONE
  } state_t;

endpackage

>>> rtl/swt_if.sv
// Valid/ready channel interfaces for the sleep and wait table.
// Depends on nothing; payload widths are fixed by the block's fields.
interface swt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] thread_tag;
  logic [31:0] condition;
  logic [31:0] duration_sec;
  logic [29:0] duration_nsec;
  modport source (output valid, mode, thread_tag, condition, duration_sec,
                  duration_nsec, input ready);
  modport sink (input valid, mode, thread_tag, condition, duration_sec,
                duration_nsec, output ready);
endinterface

interface swt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] woken_tag;
  logic        woke;
  logic        found;
  logic        table_full;
  logic        timer_active;
  logic        last;
  modport source (output valid, woken_tag, woke, found, table_full,
                  timer_active, last, input ready);
  modport sink (input valid, woken_tag, woke, found, table_full,
                timer_active, last, output ready);
endinterface

>>> rtl/sleep_and_wait_table.sv
// Top level of the sleep and wait table: sequencer, both tables, one shared
// compare/add unit. Depends on swt_pkg and the channel interfaces in swt_if.
//
// Use: requests arrive on in_ch (valid/ready), results leave on out_ch.
// cfg_we with cfg_wdata writes tick_nanos (30 bits); the user must write it
// only while the block is idle, a rule the block itself leaves unchecked.
// Every request yields one or more result items; last marks the final one.
// A tick or wakeup walks its table one entry per cycle through a single
// 64-bit add and compare unit, compacting survivors in place. Each woken
// thread is held in a pending slot until the next one is found, so the last
// woken thread leaves as the final item of its request. A condition wait, a
// zero-length sleep or an unused mode goes straight to the final item; a
// timed sleep first forms its deadline (the 32x30 multiply split into 16-bit
// halves), and a tick, wakeup or check first walks its valid entries. One
// request at a time: in_ch.ready is high only in the idle state, from the
// cycle after the final item is made. Reset clears both fill counts, the
// timer flag and sets tick_nanos to 1000000; table contents are not cleared.
// An output register holds each item until taken; a stalled receiver holds
// the walk at a further woken entry and delays the final item.
module sleep_and_wait_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [29:0] cfg_wdata,
  swt_in_if.sink      in_ch,
  swt_out_if.source   out_ch
);
  import swt_pkg::*;

  // Table storage; valid entries form a prefix given by the fill counts.
  logic [15:0] t_tag_r  [TIMED_ENTRIES];
  logic [62:0] t_dl_r   [TIMED_ENTRIES];
  logic [63:0] t_el_r   [TIMED_ENTRIES];
  logic [15:0] w_tag_r  [WAIT_ENTRIES];
  logic [31:0] w_cond_r [WAIT_ENTRIES];
  logic [TCNT_W-1:0] t_cnt_r, t_cnt_nxt;
  logic [WCNT_W-1:0] w_cnt_r, w_cnt_nxt;

  state_t state_r, state_nxt;
  logic [29:0] tick_nanos_r;
  logic        timer_r, timer_nxt;
  logic [2:0]  mode_r;
  logic [15:0] tag_r;
  logic [31:0] cond_r;
  logic [31:0] sec_r;
  logic [29:0] nsec_r;
  logic [62:0] prod_r, prod_nxt;
  logic        half_r, half_nxt;
  logic [6:0]  rd_r, rd_nxt;
  logic [6:0]  wr_r, wr_nxt;
  logic [4:0]  nres_r, nres_nxt;
  logic        found_r, found_nxt;
  logic [15:0] ptag_r, ptag_nxt;

  logic        o_valid_r, o_valid_nxt;
  logic [15:0] o_tag_r, o_tag_nxt;
  logic        o_woke_r, o_woke_nxt, o_found_r, o_found_nxt;
  logic        o_full_r, o_full_nxt, o_last_r, o_last_nxt;
  logic        o_act_r, o_act_nxt;

  logic        out_free;
  logic        t_scan, scan_end, hit;
  logic [63:0] el_sum;
  logic [TIDX_W-1:0] t_ri, t_wi;
  logic [WIDX_W-1:0] w_ri, w_wi;
  logic        t_move, w_move, t_ins, w_ins;
  logic [31:0] mul_a;
  logic [61:0] mul_p;

  assign out_free = !o_valid_r || out_ch.ready;
  assign t_scan   = (mode_r == MODE_TICK);
  assign t_ri = rd_r[TIDX_W-1:0];
  assign t_wi = wr_r[TIDX_W-1:0];
  assign w_ri = rd_r[WIDX_W-1:0];
  assign w_wi = wr_r[WIDX_W-1:0];

  // Shared unit: one 64-bit add and one compare for the entry under the walk.
  assign el_sum   = t_el_r[t_ri] + {34'd0, tick_nanos_r};
  assign scan_end = t_scan ? (rd_r >= 7'(t_cnt_r)) : (rd_r >= 7'(w_cnt_r));
  assign hit = t_scan ? (el_sum >= {1'b0, t_dl_r[t_ri]}) : (w_cond_r[w_ri] == cond_r);

  // Deadline multiplier: 16x30 per cycle, two halves of duration_sec.
  assign mul_a = half_r ? {16'd0, sec_r[31:16]} : {16'd0, sec_r[15:0]};
  assign mul_p = 62'(mul_a) * 62'(NANOS_PER_SEC);

  // Sequencer next state and outputs.
  always_comb begin
    state_nxt = state_r;
    t_cnt_nxt = t_cnt_r;
    w_cnt_nxt = w_cnt_r;
    timer_nxt = timer_r;
    prod_nxt = prod_r;
    half_nxt = half_r;
    rd_nxt = rd_r;
    wr_nxt = wr_r;
    nres_nxt = nres_r;
    found_nxt = found_r;
    ptag_nxt = ptag_r;
    o_valid_nxt = o_valid_r && !out_ch.ready;
    o_tag_nxt = o_tag_r;
    o_woke_nxt = o_woke_r;
    o_found_nxt = o_found_r;
    o_full_nxt = o_full_r;
    o_last_nxt = o_last_r;
    o_act_nxt = o_act_r;
    t_move = 1'b0;
    w_move = 1'b0;
    t_ins = 1'b0;
    w_ins = 1'b0;
    case (state_r)
      ST_IDLE: begin
        rd_nxt = '0;
        wr_nxt = '0;
        nres_nxt = '0;
        found_nxt = 1'b0;
        prod_nxt = '0;
        half_nxt = 1'b0;
        if (in_ch.valid) begin
          case (in_ch.mode)
            MODE_TICK: begin
              state_nxt = ST_SCAN;
              if (t_cnt_r == '0) timer_nxt = 1'b0;
            end
            MODE_SLEEP: begin
              if (in_ch.duration_sec != '0 || in_ch.duration_nsec != '0) begin
                state_nxt = ST_MUL;
              end else begin
                state_nxt = ST_DONE;
              end
            end
            MODE_WAIT, MODE_WAKEUP, MODE_CHECK: begin
              state_nxt = (in_ch.mode == MODE_WAIT) ? ST_DONE : ST_SCAN;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        half_nxt = 1'b1;
        if (!half_r) begin
          prod_nxt = 63'(mul_p) + 63'(nsec_r);
        end else begin
          prod_nxt = prod_r + {mul_p[46:0], 16'd0};
          state_nxt = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          if (t_scan) t_cnt_nxt = TCNT_W'(wr_r);
          else if (mode_r == MODE_WAKEUP) w_cnt_nxt = WCNT_W'(wr_r);
          state_nxt = ST_DONE;
        end else if (mode_r == MODE_CHECK) begin
          if (hit) found_nxt = 1'b1;
          rd_nxt = rd_r + 7'd1;
        end else if (hit && nres_r != 5'd16) begin
          // Woken entry: the previous pending one leaves as a non-final item.
          if (nres_r == '0 || out_free) begin
            if (nres_r != '0) begin
              o_valid_nxt = 1'b1;
              o_tag_nxt = ptag_r;
              o_woke_nxt = 1'b1;
              o_found_nxt = 1'b0;
              o_full_nxt = 1'b0;
              o_last_nxt = 1'b0;
              o_act_nxt = timer_r;
            end
            ptag_nxt = t_scan ? t_tag_r[t_ri] : w_tag_r[w_ri];
            nres_nxt = nres_r + 5'd1;
            rd_nxt = rd_r + 7'd1;
          end
        end else begin
          t_move = t_scan;
          w_move = !t_scan;
          rd_nxt = rd_r + 7'd1;
          wr_nxt = wr_r + 7'd1;
        end
      end
      ST_DONE: begin
        // Inserts happen here, along with the final item of the request.
        if (out_free) begin
          o_valid_nxt = 1'b1;
          o_tag_nxt = (nres_r != '0) ? ptag_r : 16'd0;
          o_woke_nxt = (nres_r != '0);
          o_found_nxt = found_r;
          o_full_nxt = 1'b0;
          o_last_nxt = 1'b1;
          if (mode_r == MODE_SLEEP && (sec_r != '0 || nsec_r != '0)) begin
            if (t_cnt_r == TCNT_W'(TIMED_ENTRIES)) begin
              o_full_nxt = 1'b1;
            end else begin
              t_ins = 1'b1;
              t_cnt_nxt = t_cnt_r + 1'b1;
              timer_nxt = 1'b1;
            end
          end else if (mode_r == MODE_SLEEP || mode_r == MODE_WAIT) begin
            if (w_cnt_r == WCNT_W'(WAIT_ENTRIES)) o_full_nxt = 1'b1;
            else begin
              w_ins = 1'b1;
              w_cnt_nxt = w_cnt_r + 1'b1;
            end
          end
          o_act_nxt = timer_nxt;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      t_cnt_r <= '0;
      w_cnt_r <= '0;
      timer_r <= 1'b0;
      tick_nanos_r <= TICK_NANOS_RESET;
      o_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      t_cnt_r <= t_cnt_nxt;
      w_cnt_r <= w_cnt_nxt;
      timer_r <= timer_nxt;
      if (cfg_we) tick_nanos_r <= cfg_wdata;
      o_valid_r <= o_valid_nxt;
    end
  end

  // Payload and table registers.
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    half_r <= half_nxt;
    rd_r <= rd_nxt;
    wr_r <= wr_nxt;
    nres_r <= nres_nxt;
    found_r <= found_nxt;
    ptag_r <= ptag_nxt;
    o_tag_r <= o_tag_nxt;
    o_woke_r <= o_woke_nxt;
    o_found_r <= o_found_nxt;
    o_full_r <= o_full_nxt;
    o_last_r <= o_last_nxt;
    o_act_r <= o_act_nxt;
    if (in_ch.valid && in_ch.ready) begin
      mode_r <= in_ch.mode;
      tag_r <= in_ch.thread_tag;
      cond_r <= in_ch.condition;
      sec_r <= in_ch.duration_sec;
      nsec_r <= in_ch.duration_nsec;
    end
    if (t_move) begin
      t_tag_r[t_wi] <= t_tag_r[t_ri];
      t_dl_r[t_wi] <= t_dl_r[t_ri];
      t_el_r[t_wi] <= el_sum;
    end
    if (t_ins) begin
      t_tag_r[t_cnt_r[TIDX_W-1:0]] <= tag_r;
      t_dl_r[t_cnt_r[TIDX_W-1:0]] <= prod_r;
      t_el_r[t_cnt_r[TIDX_W-1:0]] <= '0;
    end
    if (w_move) begin
      w_tag_r[w_wi] <= w_tag_r[w_ri];
      w_cond_r[w_wi] <= w_cond_r[w_ri];
    end
    if (w_ins) begin
      w_tag_r[w_cnt_r[WIDX_W-1:0]] <= tag_r;
      w_cond_r[w_cnt_r[WIDX_W-1:0]] <= cond_r;
    end
  end

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = o_valid_r;
  assign out_ch.woken_tag    = o_tag_r;
  assign out_ch.woke         = o_woke_r;
  assign out_ch.found        = o_found_r;
  assign out_ch.table_full   = o_full_r;
  assign out_ch.timer_active = o_act_r;
  assign out_ch.last         = o_last_r;

  // Assertions.
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid || out_ch.last) else $error("busy idle");
  a_tcnt: assert property (@(posedge clk) disable iff (!rst_n)
    t_cnt_r <= TCNT_W'(TIMED_ENTRIES)) else $error("timed count");
  a_wcnt: assert property (@(posedge clk) disable iff (!rst_n)
    w_cnt_r <= WCNT_W'(WAIT_ENTRIES)) else $error("wait count");
  a_nres: assert property (@(posedge clk) disable iff (!rst_n)
    nres_r <= 5'd16) else $error("too many wakes");
endmodule
